// ----- rtl/core/urfp_pkg.sv -----
// ----------------------------------------------------------------------------
// urfp_pkg
// Shared constants, types and pointer helpers for the receive FIFO
// packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package urfp_pkg;

  localparam int RING_DEPTH = 128;
  localparam int MAX_PACKET = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int LEN_W      = 7;
  localparam int BYTE_W     = 8;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [PTR_W:0]   ptr_ext_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam ptr_ext_t DEPTH_EXT = ptr_ext_t'(RING_DEPTH);
  localparam ptr_ext_t MAX_EXT   = ptr_ext_t'(MAX_PACKET);

  typedef struct packed {
    logic store;
    logic flush;
    logic load;
    logic commit;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_issue;
  } status_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t res;
    if (p == ptr_t'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + ptr_t'(1);
    end
    return res;
  endfunction

  function automatic ptr_t ptr_add(input ptr_t p, input len_t n);
    ptr_ext_t sum;
    sum = ptr_ext_t'(p) + ptr_ext_t'(n);
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/urfp_ram.sv -----
// ----------------------------------------------------------------------------
// urfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module urfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/urfp_dp.sv -----
// ----------------------------------------------------------------------------
// urfp_dp
// Datapath: ring pointers, ring memory, packet length and issue counter,
// and the result strobe pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module urfp_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire urfp_pkg::cmd_t    cmd,
  output urfp_pkg::status_t      status,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   out_valid,
  output logic [7:0]             out_packet_byte,
  output logic                   out_last_of_packet,
  output logic [6:0]             out_packet_length
);

  urfp_pkg::ptr_t     wp_r, wp_nxt;
  urfp_pkg::ptr_t     rp_r, rp_nxt;
  urfp_pkg::ptr_t     rd_addr_r, rd_addr_nxt;
  urfp_pkg::len_t     len_r, len_nxt;
  urfp_pkg::len_t     idx_r, idx_nxt;
  urfp_pkg::len_t     olen_r;
  logic               valid_r;
  logic               last_r;
  urfp_pkg::ptr_ext_t occ;
  urfp_pkg::len_t     pkt_len;

  always_comb begin
    if (wp_r >= rp_r) begin
      occ = urfp_pkg::ptr_ext_t'(wp_r) - urfp_pkg::ptr_ext_t'(rp_r);
    end else begin
      occ = urfp_pkg::ptr_ext_t'(wp_r) + urfp_pkg::DEPTH_EXT - urfp_pkg::ptr_ext_t'(rp_r);
    end
    if (occ > urfp_pkg::MAX_EXT) begin
      pkt_len = urfp_pkg::len_t'(urfp_pkg::MAX_PACKET);
    end else begin
      pkt_len = urfp_pkg::len_t'(occ);
    end
  end

  assign status.full       = (urfp_pkg::ptr_inc(wp_r) == rp_r);
  assign status.empty      = (wp_r == rp_r);
  assign status.last_issue = ((idx_r + urfp_pkg::len_t'(1)) == len_r);

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    rd_addr_nxt = rd_addr_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    if (cmd.store) begin
      wp_nxt = urfp_pkg::ptr_inc(wp_r);
    end
    if (cmd.flush) begin
      rp_nxt = wp_r;
    end
    if (cmd.load) begin
      rd_addr_nxt = rp_r;
      len_nxt     = pkt_len;
      idx_nxt     = '0;
      if (cmd.commit) begin
        rp_nxt = urfp_pkg::ptr_add(rp_r, pkt_len);
      end
    end
    if (cmd.step) begin
      rd_addr_nxt = urfp_pkg::ptr_inc(rd_addr_r);
      idx_nxt     = idx_r + urfp_pkg::len_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      valid_r <= cmd.step;
    end
    rd_addr_r <= rd_addr_nxt;
    len_r     <= len_nxt;
    idx_r     <= idx_nxt;
    last_r    <= cmd.step & status.last_issue;
    olen_r    <= len_r;
  end

  urfp_ram #(
    .WIDTH (urfp_pkg::BYTE_W),
    .DEPTH (urfp_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (wp_r),
    .wr_data (in_rx_byte),
    .rd_addr (cmd.step ? rd_addr_r : rp_r),
    .rd_data (out_packet_byte)
  );

  assign out_valid          = valid_r;
  assign out_last_of_packet = last_r;
  assign out_packet_length  = olen_r;

  a_step_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> valid_r)
    else $error("issued read did not produce a result strobe");

  a_store_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> (wp_r != rp_r))
    else $error("ring empty right after a store");

  a_flush_empty : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (wp_r == rp_r))
    else $error("ring not empty after a flush");

  a_last_valid : assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> valid_r)
    else $error("last marker without result strobe");

endmodule

`default_nettype wire

// ----- rtl/core/urfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// urfp_ctrl
// Controller: decodes accepted transactions into datapath commands and
// sequences the packet read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module urfp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_req_type,
  input  wire logic              in_rx_error,
  input  wire logic              in_usb_configured,
  input  wire logic              in_sink_accepts,
  input  wire urfp_pkg::status_t status,
  output urfp_pkg::cmd_t         cmd,
  output logic                   busy
);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  assign accept = start & ~busy_r;

  always_comb begin
    cmd.store  = accept & ~in_req_type & ~in_rx_error & ~status.full;
    cmd.flush  = accept & in_req_type & ~in_usb_configured;
    cmd.load   = accept & in_req_type & in_usb_configured & ~status.empty;
    cmd.commit = cmd.load & in_sink_accepts;
    cmd.step   = (state_r == ST_SEND);
  end

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_SEND;
          busy_nxt  = 1'b1;
        end
      end
      ST_SEND: begin
        if (status.last_issue) begin
          state_nxt = ST_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  a_load_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> busy_r)
    else $error("packet load did not raise busy");

  a_last_release : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND && status.last_issue) |=> !busy_r)
    else $error("busy held past the last byte");

endmodule

`default_nettype wire

// ----- rtl/core/uart_rx_fifo_packetizer.sv -----
// ----------------------------------------------------------------------------
// uart_rx_fifo_packetizer
// Ring FIFO between a serial receiver and a packet sink; a drain emits up to
// MAX_PACKET queued bytes as one packet.
// ----------------------------------------------------------------------------
// Receive and flush transactions leave busy low.
// A drain holds busy while its bytes are read, one ring read per cycle.
// The first result strobe of a drain passes the state register and the valid register, then one per cycle.
// Results cannot be stalled; out_valid marks each result byte for a single cycle.
// Synchronous active-low reset empties the ring; ring contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rx_fifo_packetizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_rx_error,
  input  wire logic       in_usb_configured,
  input  wire logic       in_sink_accepts,
  output logic            out_valid,
  output logic [7:0]      out_packet_byte,
  output logic            out_last_of_packet,
  output logic [6:0]      out_packet_length
);

  urfp_pkg::cmd_t    cmd;
  urfp_pkg::status_t status;

  urfp_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_req_type       (in_req_type),
    .in_rx_error       (in_rx_error),
    .in_usb_configured (in_usb_configured),
    .in_sink_accepts   (in_sink_accepts),
    .status            (status),
    .cmd               (cmd),
    .busy              (busy)
  );

  urfp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_packet_byte    (out_packet_byte),
    .out_last_of_packet (out_last_of_packet),
    .out_packet_length  (out_packet_length)
  );

endmodule

`default_nettype wire
